// File: rtl/core/spwh_pkg.sv
// ----------------------------------------------------------------------------
// spwh_pkg
// Shared constants, types and byte mapping for the position-weighted hash.
// ----------------------------------------------------------------------------
package spwh_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned HashW = 32;
	localparam int unsigned ModeW = 2;

	localparam logic [HashW-1:0] HashModulus    = 32'h8000_000b;
	localparam logic [HashW-1:0] HashMultiplier = 32'hffff_ffef;
	localparam logic [HashW-1:0] HashFinalXor   = 32'h1234_5678;
	localparam logic [CharW-1:0] CaseOffset     = 8'h20;

	localparam logic [CharW-1:0] CharUpperA = 8'h41;
	localparam logic [CharW-1:0] CharUpperZ = 8'h5a;
	localparam logic [CharW-1:0] CharSlash  = 8'h2f;
	localparam logic [CharW-1:0] CharBslash = 8'h5c;

	localparam logic [ModeW-1:0] ModePlain = 2'd0;

	// controller to datapath
	typedef struct packed {
		logic take_char;   // register pos * byte
		logic reduce;      // acc + product, one conditional subtract
		logic scale;       // acc <= reduced * multiplier, advance position
		logic finish;      // load output word, clear state
	} spwh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic char_zero;
	} spwh_sts_t;

	function automatic logic [CharW-1:0] map_char(
		input logic [CharW-1:0] b,
		input logic [ModeW-1:0] mode
	);
		logic [CharW-1:0] r;
		r = b;
		if (mode != ModePlain) begin
			if (b >= CharUpperA && b <= CharUpperZ) begin
				r = b + CaseOffset;
			end else if (mode[1] && b == CharSlash) begin
				r = CharBslash;
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/string_position_weighted_hash.sv
// ----------------------------------------------------------------------------
// string_position_weighted_hash
// Position-weighted 32-bit hash of zero-terminated byte strings.
// ----------------------------------------------------------------------------
// One character word per input handshake. For a nonzero character the accept
// cycle registers position * signed character in a 32x32 multiplier, the
// reduce state adds the accumulator and subtracts 0x8000000b once if the sum is
// not below it, and the scale state multiplies by 0xffffffef and advances the
// position; no new character is taken until the scale state is done. A zero
// character loads acc ^ 0x12345678 into the output register and restarts the
// state. A waiting output word blocks input only until it is taken. hash_mode
// (0 plain, 1 fold case, 2 or 3 fold case and map '/' to '\') may be written
// when the block is idle and applies from the next character on.
// ----------------------------------------------------------------------------
module string_position_weighted_hash
	import spwh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ModeW-1:0] cfg_wdata,       // hash_mode
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [CharW-1:0] s_axis_tdata,    // [7:0] char_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [HashW-1:0] m_axis_tdata     // [31:0] hash_value
);

	spwh_cmd_t cmd;
	spwh_sts_t sts;

	spwh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	spwh_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.char_byte  (s_axis_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.hash_value (m_axis_tdata)
	);

endmodule

// File: rtl/core/spwh_datapath.sv
// ----------------------------------------------------------------------------
// spwh_datapath
// Accumulator, position count, product and reduce registers, output word.
// ----------------------------------------------------------------------------
module spwh_datapath
	import spwh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ModeW-1:0] cfg_wdata,
	input  logic [CharW-1:0] char_byte,
	input  spwh_cmd_t        cmd,
	output spwh_sts_t        sts,
	output logic [HashW-1:0] hash_value
);

	logic [ModeW-1:0] mode_q;
	logic [HashW-1:0] acc_q;
	logic [HashW-1:0] pos_q;
	logic [HashW-1:0] prod_q;
	logic [HashW-1:0] red_q;
	logic [HashW-1:0] hash_q;

	logic [CharW-1:0] mapped;
	logic [HashW-1:0] char_sx;
	logic [HashW-1:0] sum;
	logic [HashW-1:0] red_next;

	assign sts.char_zero = (char_byte == '0);
	assign mapped        = map_char(char_byte, mode_q);
	assign char_sx       = {{(HashW-CharW){mapped[CharW-1]}}, mapped};
	assign sum           = acc_q + prod_q;
	assign red_next      = (sum >= HashModulus) ? (sum - HashModulus) : sum;
	assign hash_value    = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModePlain;
			acc_q  <= '0;
			pos_q  <= HashW'(1);
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.scale) begin
				acc_q <= red_q * HashMultiplier;
				pos_q <= pos_q + HashW'(1);
			end else if (cmd.finish) begin
				acc_q <= '0;
				pos_q <= HashW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take_char) begin
			prod_q <= pos_q * char_sx;
		end
		if (cmd.reduce) begin
			red_q <= red_next;
		end
		if (cmd.finish) begin
			hash_q <= acc_q ^ HashFinalXor;
		end
	end

endmodule

// File: rtl/core/spwh_ctrl.sv
// ----------------------------------------------------------------------------
// spwh_ctrl
// Sequencer for one character and the output word handshake.
// ----------------------------------------------------------------------------
module spwh_ctrl
	import spwh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_axis_tvalid,
	output logic      s_axis_tready,
	output logic      m_axis_tvalid,
	input  logic      m_axis_tready,
	input  spwh_sts_t sts,
	output spwh_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCALE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// the output word may be overwritten in the cycle it is taken
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		cmd.take_char = accept && !sts.char_zero;
		cmd.finish    = accept && sts.char_zero;
		cmd.reduce    = (state_q == ST_REDUCE);
		cmd.scale     = (state_q == ST_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take_char) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_char, cmd.reduce, cmd.scale, cmd.finish}))
		else $error("more than one datapath command");

	a_busy_after_char: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_char |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("character accepted while sequence running");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_axis_tready))
		else $error("pending output word overwritten");

	a_reduce_then_scale: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reduce |=> cmd.scale)
		else $error("reduce not followed by scale");

endmodule
